[rtl/core/bpst_pkg.sv]
// ----------------------------------------------------------------------------
// bpst_pkg
// Shared constants and types for the box versus plane side test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bpst_pkg;

  // Default field widths: coordinates Q16.16, normals Q2.14
  localparam int COORD_WIDTH_DEF  = 32;
  localparam int NORMAL_WIDTH_DEF = 16;

  // Plane type codes; every type at or above AXIAL_TYPES is a general plane
  localparam logic [2:0] PLANE_AXIAL_X = 3'd0;
  localparam logic [2:0] PLANE_AXIAL_Y = 3'd1;
  localparam logic [2:0] PLANE_AXIAL_Z = 3'd2;
  localparam logic [2:0] AXIAL_TYPES   = 3'd3;

  // Side codes
  localparam logic [1:0] SIDES_FRONT = 2'b01;
  localparam logic [1:0] SIDES_BACK  = 2'b10;
  localparam logic [1:0] SIDES_BOTH  = 2'b11;

  // Load enables of the dot product stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } pipe_en_t;

endpackage

`default_nettype wire

[rtl/core/bpst_if.sv]
// ----------------------------------------------------------------------------
// bpst_if
// Valid/ready channels carrying box/plane items and side results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bpst_in_if #(
  parameter int COORD_WIDTH  = bpst_pkg::COORD_WIDTH_DEF,
  parameter int NORMAL_WIDTH = bpst_pkg::NORMAL_WIDTH_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic signed [NORMAL_WIDTH-1:0] normal_x;
  logic signed [NORMAL_WIDTH-1:0] normal_y;
  logic signed [NORMAL_WIDTH-1:0] normal_z;
  logic signed [COORD_WIDTH-1:0]  plane_dist;
  logic        [2:0]              plane_type;
  logic        [2:0]              sign_bits;
  logic signed [COORD_WIDTH-1:0]  min_x;
  logic signed [COORD_WIDTH-1:0]  min_y;
  logic signed [COORD_WIDTH-1:0]  min_z;
  logic signed [COORD_WIDTH-1:0]  max_x;
  logic signed [COORD_WIDTH-1:0]  max_y;
  logic signed [COORD_WIDTH-1:0]  max_z;

  modport source (
    output valid, normal_x, normal_y, normal_z, plane_dist, plane_type, sign_bits,
           min_x, min_y, min_z, max_x, max_y, max_z,
    input  ready
  );
  modport sink (
    input  valid, normal_x, normal_y, normal_z, plane_dist, plane_type, sign_bits,
           min_x, min_y, min_z, max_x, max_y, max_z,
    output ready
  );
endinterface

interface bpst_out_if ();
  logic       valid;
  logic       ready;
  logic [1:0] sides;

  modport source (output valid, sides, input ready);
  modport sink (input valid, sides, output ready);
endinterface

`default_nettype wire

[rtl/core/bpst_dot3.sv]
// ----------------------------------------------------------------------------
// bpst_dot3
// Three stage exact dot product of a box corner with the plane normal:
// split partial products, product assembly, three term sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bpst_dot3 #(
  parameter int COORD_WIDTH  = bpst_pkg::COORD_WIDTH_DEF,
  parameter int NORMAL_WIDTH = bpst_pkg::NORMAL_WIDTH_DEF,
  localparam int SumWidth    = COORD_WIDTH + NORMAL_WIDTH + 2
) (
  input  wire                           clk_i,
  input  wire bpst_pkg::pipe_en_t       en_i,
  input  wire logic signed [COORD_WIDTH-1:0]  coord_i  [3],
  input  wire logic signed [NORMAL_WIDTH-1:0] normal_i [3],
  output logic signed [SumWidth-1:0]    sum_o
);

  localparam int LoWidth   = COORD_WIDTH / 2;
  localparam int HiWidth   = COORD_WIDTH - LoWidth;
  localparam int ProdWidth = COORD_WIDTH + NORMAL_WIDTH;
  localparam int LoProdW   = LoWidth + NORMAL_WIDTH + 1;
  localparam int HiProdW   = HiWidth + NORMAL_WIDTH;

  logic signed [LoProdW-1:0]   lo_q   [3];
  logic signed [HiProdW-1:0]   hi_q   [3];
  logic signed [ProdWidth-1:0] prod_q [3];
  logic signed [SumWidth-1:0]  sum_q;

  // Stage 1: low half unsigned times normal, high half signed times normal
  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      for (int i = 0; i < 3; i++) begin
        lo_q[i] <= LoProdW'($signed({1'b0, coord_i[i][LoWidth-1:0]}))
                   * LoProdW'(normal_i[i]);
        hi_q[i] <= HiProdW'($signed(coord_i[i][COORD_WIDTH-1:LoWidth]))
                   * HiProdW'(normal_i[i]);
      end
    end
  end

  // Stage 2: assemble the exact products
  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      for (int i = 0; i < 3; i++) begin
        prod_q[i] <= (ProdWidth'(hi_q[i]) <<< LoWidth) + ProdWidth'(lo_q[i]);
      end
    end
  end

  // Stage 3: sum of the three axes, two guard bits keep it exact
  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      sum_q <= SumWidth'(prod_q[0]) + SumWidth'(prod_q[1]) + SumWidth'(prod_q[2]);
    end
  end

  assign sum_o = sum_q;

endmodule

`default_nettype wire

[rtl/core/box_plane_side_test.sv]
// ----------------------------------------------------------------------------
// box_plane_side_test
// Throughput: one item per cycle while out_o.ready holds, through four register
// stages (split multiply, product assembly, dot product sum, distance compare and
// output register). Each stage stalls only when it holds an item that the next
// cannot take. Reset clears the stage valid bits only; no state is kept between
// items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module box_plane_side_test #(
  parameter int COORD_WIDTH  = bpst_pkg::COORD_WIDTH_DEF,
  parameter int NORMAL_WIDTH = bpst_pkg::NORMAL_WIDTH_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  bpst_in_if.sink    in_i,
  bpst_out_if.source out_o
);

  localparam int SumWidth = COORD_WIDTH + NORMAL_WIDTH + 2;

  // Handshake chain: a stage loads when it is empty or the next one moves
  logic valid1_q, valid2_q, valid3_q, valid4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  bpst_pkg::pipe_en_t dot_en;

  assign rdy4 = !valid4_q || out_o.ready;
  assign rdy3 = !valid3_q || rdy4;
  assign rdy2 = !valid2_q || rdy3;
  assign rdy1 = !valid1_q || rdy2;
  assign in_i.ready = rdy1;

  assign dot_en.s1 = rdy1;
  assign dot_en.s2 = rdy2;
  assign dot_en.s3 = rdy3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
      valid3_q <= 1'b0;
      valid4_q <= 1'b0;
    end else begin
      if (rdy1) valid1_q <= in_i.valid;
      if (rdy2) valid2_q <= valid1_q;
      if (rdy3) valid3_q <= valid2_q;
      if (rdy4) valid4_q <= valid3_q;
    end
  end

  // Axial test and corner selection on the incoming item
  logic signed [COORD_WIDTH-1:0]  ax_min, ax_max;
  logic                           axial;
  logic [1:0]                     ax_sides;
  logic signed [COORD_WIDTH-1:0]  mins [3];
  logic signed [COORD_WIDTH-1:0]  maxs [3];
  logic signed [COORD_WIDTH-1:0]  front_c [3];
  logic signed [COORD_WIDTH-1:0]  back_c [3];
  logic signed [NORMAL_WIDTH-1:0] normals [3];

  always_comb begin
    case (in_i.plane_type)
      bpst_pkg::PLANE_AXIAL_X: begin ax_min = in_i.min_x; ax_max = in_i.max_x; end
      bpst_pkg::PLANE_AXIAL_Y: begin ax_min = in_i.min_y; ax_max = in_i.max_y; end
      bpst_pkg::PLANE_AXIAL_Z: begin ax_min = in_i.min_z; ax_max = in_i.max_z; end
      default:                 begin ax_min = in_i.min_x; ax_max = in_i.max_x; end
    endcase
    axial = in_i.plane_type < bpst_pkg::AXIAL_TYPES;
    // Front test wins when the box is inverted
    if (in_i.plane_dist <= ax_min) begin
      ax_sides = bpst_pkg::SIDES_FRONT;
    end else if (ax_max <= in_i.plane_dist) begin
      ax_sides = bpst_pkg::SIDES_BACK;
    end else begin
      ax_sides = bpst_pkg::SIDES_BOTH;
    end
  end

  assign mins    = '{in_i.min_x, in_i.min_y, in_i.min_z};
  assign maxs    = '{in_i.max_x, in_i.max_y, in_i.max_z};
  assign normals = '{in_i.normal_x, in_i.normal_y, in_i.normal_z};

  // A negative normal component takes the min bound for the front corner
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      front_c[i] = in_i.sign_bits[i] ? mins[i] : maxs[i];
      back_c[i]  = in_i.sign_bits[i] ? maxs[i] : mins[i];
    end
  end

  logic signed [SumWidth-1:0] front_sum, back_sum;

  bpst_dot3 #(
    .COORD_WIDTH  (COORD_WIDTH),
    .NORMAL_WIDTH (NORMAL_WIDTH)
  ) u_dot_front (
    .clk_i    (clk_i),
    .en_i     (dot_en),
    .coord_i  (front_c),
    .normal_i (normals),
    .sum_o    (front_sum)
  );

  bpst_dot3 #(
    .COORD_WIDTH  (COORD_WIDTH),
    .NORMAL_WIDTH (NORMAL_WIDTH)
  ) u_dot_back (
    .clk_i    (clk_i),
    .en_i     (dot_en),
    .coord_i  (back_c),
    .normal_i (normals),
    .sum_o    (back_sum)
  );

  // Carry the distance and axial result alongside the dot products
  logic signed [COORD_WIDTH-1:0] dist1_q, dist2_q, dist3_q;
  logic                          axial1_q, axial2_q, axial3_q;
  logic [1:0]                    ax_sides1_q, ax_sides2_q, ax_sides3_q;
  logic [1:0]                    sides_q;

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      dist1_q     <= in_i.plane_dist;
      axial1_q    <= axial;
      ax_sides1_q <= ax_sides;
    end
    if (rdy2) begin
      dist2_q     <= dist1_q;
      axial2_q    <= axial1_q;
      ax_sides2_q <= ax_sides1_q;
    end
    if (rdy3) begin
      dist3_q     <= dist2_q;
      axial3_q    <= axial2_q;
      ax_sides3_q <= ax_sides2_q;
    end
  end

  // Align the distance to the product fraction and compare
  logic signed [SumWidth-1:0] dist_ext;
  logic                       front_ge, back_lt;

  assign dist_ext = $signed({{4{dist3_q[COORD_WIDTH-1]}}, dist3_q,
                             {(NORMAL_WIDTH-2){1'b0}}});
  assign front_ge = front_sum >= dist_ext;
  assign back_lt  = back_sum < dist_ext;

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      sides_q <= axial3_q ? ax_sides3_q : {back_lt, front_ge};
    end
  end

  assign out_o.valid = valid4_q;
  assign out_o.sides = sides_q;

`ifndef NO_ASSERTIONS
  // A taken output frees the whole chain for a new item
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_o.ready |-> in_i.ready)
    else $error("input not ready while output is taken");

  // A mid stage item blocked by a full output stage stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   valid3_q && !rdy4 |=> valid3_q)
    else $error("stage 3 item lost under stall");

  // An axial item never carries an empty side code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   valid1_q && axial1_q |-> ax_sides1_q != 2'b00)
    else $error("axial item with no side");
`endif

endmodule

`default_nettype wire
